[src/salc_pkg.sv]
// Package for the set-associative LRU cache timing model.
// Types, constants and a helper function shared by the front, back and top modules; no dependencies.
package salc_pkg;

   localparam int NumSetsDef    = 64;
   localparam int WaysDef       = 8;
   localparam int OffsetBitsDef = 6;
   localparam int AddrBitsDef   = 48;

   localparam int CycW  = 48;
   localparam int LatW  = 16;
   localparam int CntW  = 32;
   localparam int WayOutW = 3;
   localparam int CsrIdxW = 1;

   localparam logic [CsrIdxW-1:0] CSR_HIT_LATENCY  = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_MISS_PENALTY = 1'b1;

   localparam logic [LatW-1:0] HitLatencyRst  = 16'd1;
   localparam logic [LatW-1:0] MissPenaltyRst = 16'd100;

   localparam logic KIND_ACCESS = 1'b0;
   localparam logic KIND_PROBE  = 1'b1;

   // Saturating add of two CycW-bit time values; an overflow clamps to all ones.
   function automatic logic [CycW-1:0] sat_add(input logic [CycW-1:0] a,
                                               input logic [CycW-1:0] b);
      logic [CycW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CycW] ? {CycW{1'b1}} : s[CycW-1:0];
   endfunction

   typedef struct packed {
      logic            kind;
      logic            is_prefetch;
      logic [CycW-1:0] lat_done;
      logic [CycW-1:0] miss_done;
   } salc_cmd_type;

endpackage

[src/salc_front.sv]
// Front end: accepts requests, splits the address, adds the latencies.
// Depends on salc_pkg.
module salc_front #(
   parameter int SET_COUNT   = salc_pkg::NumSetsDef,
   parameter int OFFSET_BITS = salc_pkg::OffsetBitsDef,
   parameter int ADDR_BITS   = salc_pkg::AddrBitsDef,
   parameter int SET_W       = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1,
   parameter int TAG_W       = 36
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [salc_pkg::CycW-1:0]   req_now_cycle,
   input  logic [salc_pkg::CycW-1:0]   req_address,
   input  logic                        req_is_prefetch,
   input  logic [salc_pkg::LatW-1:0]   hit_latency,
   input  logic [salc_pkg::LatW-1:0]   miss_penalty,
   output logic                        q_valid,
   input  logic                        q_ready,
   output salc_pkg::salc_cmd_type      q_cmd,
   output logic [SET_W-1:0]            q_set,
   output logic [TAG_W-1:0]            q_tag
);
   import salc_pkg::*;

   localparam int IB = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 0;
   localparam int AW = (ADDR_BITS < CycW) ? ADDR_BITS : CycW;

   logic                valid_ff, valid_in;
   salc_cmd_type        cmd_ff, cmd_in;
   logic [SET_W-1:0]    set_ff, set_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [CycW-1:0]     addr_c, blk_c;
   logic [SET_W:0]      raw_set;

   assign req_ready = !valid_ff || q_ready;

   always_comb begin
      addr_c = '0;
      addr_c[AW-1:0] = req_address[AW-1:0];
      blk_c  = addr_c >> OFFSET_BITS;
      raw_set = '0;
      if (IB > 0) raw_set[SET_W-1:0] = blk_c[SET_W-1:0];
      if (raw_set >= (SET_W+1)'(SET_COUNT)) raw_set = raw_set - (SET_W+1)'(SET_COUNT);
      set_in = raw_set[SET_W-1:0];
      tag_in = TAG_W'(blk_c >> IB);
      cmd_in.kind        = req_kind;
      cmd_in.is_prefetch = req_is_prefetch;
      cmd_in.lat_done    = sat_add(req_now_cycle, CycW'(hit_latency));
      cmd_in.miss_done   = sat_add(cmd_in.lat_done, CycW'(miss_penalty));
      valid_in = valid_ff;
      if (req_valid && req_ready) valid_in = 1'b1;
      else if (q_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_in;
         set_ff <= set_in;
         tag_ff <= tag_in;
      end
   end

   assign q_valid = valid_ff;
   assign q_cmd   = cmd_ff;
   assign q_set   = set_ff;
   assign q_tag   = tag_ff;

`ifndef NO_ASSERTIONS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !q_ready |=> valid_ff && $stable(set_ff) && $stable(tag_ff))
      else $error("front entry lost while stalled");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> cmd_ff.miss_done >= cmd_ff.lat_done)
      else $error("miss time below hit time");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> req_ready)
      else $error("empty front stalls");
`endif
endmodule

[src/salc_back.sv]
// Back end: reads the set, compares ways, updates LRU, tags and counters.
// Depends on salc_pkg and salc_ram.
module salc_back #(
   parameter int SET_COUNT = salc_pkg::NumSetsDef,
   parameter int WAYS      = salc_pkg::WaysDef,
   parameter int SET_W     = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1,
   parameter int TAG_W     = 36
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_ready,
   input  salc_pkg::salc_cmd_type      q_cmd,
   input  logic [SET_W-1:0]            q_set,
   input  logic [TAG_W-1:0]            q_tag,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic [salc_pkg::CycW-1:0]   rsp_ready_cycle,
   output logic [salc_pkg::WayOutW-1:0] rsp_way_used,
   output logic [salc_pkg::CntW-1:0]   rsp_demand_accesses,
   output logic [salc_pkg::CntW-1:0]   rsp_demand_misses,
   output logic [salc_pkg::CntW-1:0]   rsp_prefetch_accesses,
   output logic [salc_pkg::CntW-1:0]   rsp_prefetch_misses
);
   import salc_pkg::*;

   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RK_W  = WAY_W;
   localparam int ROW_W = WAYS * (1 + TAG_W + CycW);
   localparam int LRU_W = WAYS * RK_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_RESP = 3'b100
   } st_type;

   st_type st_ff, st_in;
   logic [SET_W:0] clr_ff, clr_in;
   logic clearing;
   salc_cmd_type cmd_ff;
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [CntW-1:0] da_ff, dm_ff, pa_ff, pm_ff, da_in, dm_in, pa_in, pm_in;
   logic            hit_ff, hit_in;
   logic [CycW-1:0] rc_ff, rc_in;
   logic [WayOutW-1:0] way_ff, way_in;

   logic [ROW_W-1:0] row_rd, row_wd;
   logic [LRU_W-1:0] lru_rd, lru_wd;
   logic             mem_we;
   logic [SET_W-1:0] mem_wa, mem_ra;

   assign clearing = !clr_ff[SET_W];
   assign q_ready  = (st_ff == ST_IDLE) && !clearing;

   salc_ram #(.WIDTH(ROW_W), .DEPTH(SET_COUNT)) u_row (
      .clock(clock), .we(mem_we), .waddr(mem_wa), .wdata(row_wd),
      .raddr(mem_ra), .rdata(row_rd));
   salc_ram #(.WIDTH(LRU_W), .DEPTH(SET_COUNT)) u_lru (
      .clock(clock), .we(mem_we), .waddr(mem_wa), .wdata(lru_wd),
      .raddr(mem_ra), .rdata(lru_rd));

   assign mem_ra = q_set;

   logic [WAYS-1:0]      vld;
   logic [TAG_W-1:0]     tg [WAYS];
   logic [CycW-1:0]      tm [WAYS];
   logic [RK_W-1:0]      rk [WAYS];
   logic                 found;
   logic [WAY_W-1:0]     fway, victim, sel;
   logic [RK_W-1:0]      best, selrk;

   always_comb begin
      found = 1'b0; fway = '0; victim = '0; best = '0;
      for (int w = 0; w < WAYS; w++) begin
         vld[w] = row_rd[w*(1+TAG_W+CycW)];
         tg[w]  = row_rd[w*(1+TAG_W+CycW)+1 +: TAG_W];
         tm[w]  = row_rd[w*(1+TAG_W+CycW)+1+TAG_W +: CycW];
         rk[w]  = lru_rd[w*RK_W +: RK_W];
      end
      for (int w = WAYS-1; w >= 0; w--) begin
         if (vld[w] && tg[w] == tag_ff) begin
            found = 1'b1; fway = WAY_W'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (rk[w] >= best) begin
            best = rk[w]; victim = WAY_W'(w);
         end
      end
      sel = found ? fway : victim;
      selrk = rk[sel];
   end

   always_comb begin
      st_in = st_ff; clr_in = clr_ff;
      da_in = da_ff; dm_in = dm_ff; pa_in = pa_ff; pm_in = pm_ff;
      hit_in = hit_ff; rc_in = rc_ff; way_in = way_ff;
      mem_we = 1'b0; mem_wa = set_ff; row_wd = row_rd; lru_wd = lru_rd;
      if (clearing) begin
         mem_we = 1'b1;
         mem_wa = clr_ff[SET_W-1:0];
         row_wd = '0;
         for (int w = 0; w < WAYS; w++) lru_wd[w*RK_W +: RK_W] = RK_W'(w);
         clr_in = clr_ff + 1'b1;
         if (clr_ff == (SET_W+1)'(SET_COUNT-1)) clr_in = {1'b1, {SET_W{1'b0}}};
      end
      unique case (st_ff)
         ST_IDLE: if (q_valid && q_ready) st_in = ST_LOOK;
         ST_LOOK: begin
            st_in = ST_RESP;
            if (cmd_ff.kind == KIND_PROBE) begin
               hit_in = found && (tm[fway] <= cmd_ff.lat_done);
               rc_in  = '0;
               way_in = found ? WayOutW'(fway) : '0;
            end else begin
               if (cmd_ff.is_prefetch) pa_in = pa_ff + 1'b1;
               else da_in = da_ff + 1'b1;
               way_in = WayOutW'(sel);
               hit_in = found;
               if (found) begin
                  rc_in = (tm[fway] > cmd_ff.lat_done) ? tm[fway] : cmd_ff.lat_done;
               end else begin
                  rc_in = cmd_ff.miss_done;
                  if (cmd_ff.is_prefetch) pm_in = pm_ff + 1'b1;
                  else dm_in = dm_ff + 1'b1;
                  row_wd[sel*(1+TAG_W+CycW) +: 1+TAG_W+CycW] =
                     {cmd_ff.miss_done, tag_ff, 1'b1};
               end
               for (int w = 0; w < WAYS; w++)
                  if (rk[w] < selrk) lru_wd[w*RK_W +: RK_W] = rk[w] + 1'b1;
               lru_wd[sel*RK_W +: RK_W] = '0;
               mem_we = 1'b1;
            end
         end
         ST_RESP: if (rsp_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; clr_ff <= '0;
         da_ff <= '0; dm_ff <= '0; pa_ff <= '0; pm_ff <= '0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in;
         da_ff <= da_in; dm_ff <= dm_in; pa_ff <= pa_in; pm_ff <= pm_in;
      end
      hit_ff <= hit_in; rc_ff <= rc_in; way_ff <= way_in;
      if (q_valid && q_ready) begin
         cmd_ff <= q_cmd; set_ff <= q_set; tag_ff <= q_tag;
      end
   end

   assign rsp_valid             = (st_ff == ST_RESP);
   assign rsp_hit               = hit_ff;
   assign rsp_ready_cycle       = rc_ff;
   assign rsp_way_used          = way_ff;
   assign rsp_demand_accesses   = da_ff;
   assign rsp_demand_misses     = dm_ff;
   assign rsp_prefetch_accesses = pa_ff;
   assign rsp_prefetch_misses   = pm_ff;

`ifndef NO_ASSERTIONS
   a_busy_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !q_ready)
      else $error("request taken while result waits");
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_ready)
      else $error("request taken during clear");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rc_ff))
      else $error("response dropped");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(st_ff))
      else $error("state not one-hot");
`endif
endmodule

[src/salc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end
   assign rdata = rdata_ff;
endmodule

[src/set_assoc_lru_cache_timing.sv]
// Top level of the set-associative LRU cache timing model.
// Instantiates salc_front and salc_back; depends on salc_pkg.
//
// Usage:
//  - req_* channel: one lookup per transfer (kind, now_cycle, address,
//    is_prefetch). kind selects access-with-update or a read-only probe.
//  - rsp_* channel: one result per request, in order: hit, ready_cycle,
//    way_used and the four running demand/prefetch counters.
//  - csr_* channel: write hit_latency (index 0) or miss_penalty (index 1);
//    other indexes are dropped. Write only while the block is idle.
// Timing:
//  - The front stage registers the split address and the saturated sums.
//  - The back end takes the request and reads the set row together,
//    compares and, on access, updates in the next cycle, then holds the
//    result until rsp_ready. It takes a new request only once the result
//    has transferred, as its idle, look and response states carry out
//    the read-modify-write of the tag/LRU memories one request at a time.
//  - The front stage takes the next request while the back end works.
// Reset: clears counters and control, restores register defaults, then
//    a clearing pass invalidates every set; the back end takes no
//    request during that pass.
// A stalled receiver holds the result and, one request later, the front.
module set_assoc_lru_cache_timing #(
   parameter int SET_COUNT   = salc_pkg::NumSetsDef,
   parameter int WAYS        = salc_pkg::WaysDef,
   parameter int OFFSET_BITS = salc_pkg::OffsetBitsDef,
   parameter int ADDR_BITS   = salc_pkg::AddrBitsDef
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [salc_pkg::CycW-1:0]    req_now_cycle,
   input  logic [salc_pkg::CycW-1:0]    req_address,
   input  logic                         req_is_prefetch,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [salc_pkg::CycW-1:0]    rsp_ready_cycle,
   output logic [salc_pkg::WayOutW-1:0] rsp_way_used,
   output logic [salc_pkg::CntW-1:0]    rsp_demand_accesses,
   output logic [salc_pkg::CntW-1:0]    rsp_demand_misses,
   output logic [salc_pkg::CntW-1:0]    rsp_prefetch_accesses,
   output logic [salc_pkg::CntW-1:0]    rsp_prefetch_misses,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [salc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [salc_pkg::LatW-1:0]    csr_data
);
   import salc_pkg::*;

   localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
   localparam int IB    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 0;
   localparam int AW    = (ADDR_BITS < CycW) ? ADDR_BITS : CycW;
   // tag keeps at least one bit even when the address leaves none
   localparam int TAG_W = (AW - OFFSET_BITS - IB > 0) ? AW - OFFSET_BITS - IB : 1;

   logic [LatW-1:0] hit_lat_ff, hit_lat_in, miss_pen_ff, miss_pen_in;
   logic            q_valid, q_ready;
   salc_cmd_type    q_cmd;
   logic [SET_W-1:0] q_set;
   logic [TAG_W-1:0] q_tag;

   // configuration is always taken
   assign csr_ready = 1'b1;

   always_comb begin
      hit_lat_in  = hit_lat_ff;
      miss_pen_in = miss_pen_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HIT_LATENCY:  hit_lat_in  = csr_data;
            CSR_MISS_PENALTY: miss_pen_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_lat_ff  <= HitLatencyRst;
         miss_pen_ff <= MissPenaltyRst;
      end else begin
         hit_lat_ff  <= hit_lat_in;
         miss_pen_ff <= miss_pen_in;
      end
   end

   salc_front #(.SET_COUNT(SET_COUNT), .OFFSET_BITS(OFFSET_BITS),
                .ADDR_BITS(ADDR_BITS), .SET_W(SET_W), .TAG_W(TAG_W)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_now_cycle(req_now_cycle), .req_address(req_address),
      .req_is_prefetch(req_is_prefetch),
      .hit_latency(hit_lat_ff), .miss_penalty(miss_pen_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .q_set(q_set), .q_tag(q_tag));

   salc_back #(.SET_COUNT(SET_COUNT), .WAYS(WAYS), .SET_W(SET_W),
               .TAG_W(TAG_W)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .q_set(q_set), .q_tag(q_tag),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_ready_cycle(rsp_ready_cycle), .rsp_way_used(rsp_way_used),
      .rsp_demand_accesses(rsp_demand_accesses),
      .rsp_demand_misses(rsp_demand_misses),
      .rsp_prefetch_accesses(rsp_prefetch_accesses),
      .rsp_prefetch_misses(rsp_prefetch_misses));

`ifndef NO_ASSERTIONS
   a_cfg: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == CSR_HIT_LATENCY |=> hit_lat_ff == $past(csr_data))
      else $error("hit latency write lost");
   a_pen: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == CSR_MISS_PENALTY |=> miss_pen_ff == $past(csr_data))
      else $error("miss penalty write lost");
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("result repeated");
`endif
endmodule
